// File: sv/b64d_pkg.sv
// Shared types, character codes and the base64 alphabet lookup for the stream decoder.
package b64d_pkg;

   localparam int unsigned COUNT_MAX_DEF = 32'd65535;

   // Each accepted character yields at most three results.
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PAD   = 8'h3D;

   localparam logic [5:0] SEXTET_PLUS = 6'd62;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] count;
      logic        last;
   } result_type;

   // Results produced by one character, in delivery order; num counts them.
   typedef struct packed {
      logic [1:0]                         num;
      result_type [MAX_RESULTS-1:0]       items;
   } push_type;

   // Bit 6 set marks a character outside the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == CH_PLUS) begin
         v = 7'd62;
      end else if (c == CH_SLASH) begin
         v = 7'd63;
      end
      return v;
   endfunction

endpackage

// File: sv/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: request and response stream ports.
// Results of a request are registered in the result queue before they appear on the response port.
// Throughput: one request per cycle while the result queue has room for three results;
// a group of four characters yields at most three results and the response side hands
// out one per cycle, so with the response side ready no request is ever held back.
// Reset: synchronous, active high; clears the string state and empties the result queue.
module base64_stream_decoder_top #(
   parameter int unsigned COUNT_MAX = b64d_pkg::COUNT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [23:8] decoded_count
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // final result caused by one request
);
   import b64d_pkg::*;

   push_type   push;
   result_type head;
   logic       accept;
   logic       has_room;

   // A request is taken only when the queue can absorb the worst case of three
   // results, so the decoder never has to hold a request back on its own.
   assign req_tready = has_room;
   assign accept     = req_tvalid && req_tready;

   // The decoder turns the accepted character into zero to three results in the
   // same cycle; they are written into the queue at the clock edge.
   b64d_decode #(
      .COUNT_MAX (COUNT_MAX)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .symbol (req_tdata),
      .push   (push)
   );

   // The queue decouples the two sides, so new requests keep flowing while an
   // earlier result waits on a stalled response port.
   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .has_room   (has_room)
   );

   assign rsp_tdata = {head.count, head.data};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// File: sv/b64d_decode.sv
// Per-character decode: string state, group assembly and result generation.
module b64d_decode #(
   parameter int unsigned COUNT_MAX = b64d_pkg::COUNT_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         symbol,
   output b64d_pkg::push_type push
);
   import b64d_pkg::*;

   localparam int CNT_W = $clog2(64'(COUNT_MAX) + 64'd1);

   typedef enum logic [3:0] {
      ST_START = 4'b0001,
      ST_PLUS  = 4'b0010,
      ST_FIRST = 4'b0100,
      ST_GROUP = 4'b1000
   } phase_type;

   phase_type         phase_ff, phase_in;
   phase_type         phase_sel;
   logic [1:0]        pos_ff, pos_in;
   logic [17:0]       held_ff, held_in;
   logic              tp_ff, tp_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              do_take;
   logic              direct_done;
   logic [1:0]        t_pos;
   logic [17:0]       t_held;
   logic              t_tp;

   logic [6:0]        v;
   logic              pad;
   logic              bad;
   logic [17:0]       held_base;
   logic [5:0]        s1, s2, s3;
   logic [1:0]        nbytes;
   logic [CNT_W+1:0]  sum;
   logic [CNT_W-1:0]  count_sat;
   logic [CNT_W+15:0] count_ext;
   logic [15:0]       done_count;
   logic [7:0]        bytes [MAX_RESULTS];
   logic              new_string;
   push_type          push_c;

   // Select what the single take-character path sees in each phase. After an
   // unpaired leading plus, that plus already stands at group position zero.
   always_comb begin
      phase_sel   = phase_ff;
      do_take     = 1'b0;
      direct_done = 1'b0;
      t_pos       = pos_ff;
      t_held      = held_ff;
      t_tp        = tp_ff;
      unique case (phase_ff)
         ST_START: begin
            if (symbol == CH_PLUS) begin
               phase_sel = ST_PLUS;
            end else if (symbol == CH_CR) begin
               direct_done = 1'b1;
            end else begin
               do_take = 1'b1;
               t_pos   = 2'd0;
            end
         end
         ST_PLUS: begin
            if (symbol == CH_SPACE) begin
               phase_sel = ST_FIRST;
            end else begin
               do_take = 1'b1;
               t_pos   = 2'd1;
               t_held  = {12'd0, SEXTET_PLUS};
               t_tp    = 1'b0;
            end
         end
         ST_FIRST: begin
            if (symbol == CH_CR) begin
               direct_done = 1'b1;
            end else begin
               do_take = 1'b1;
               t_pos   = 2'd0;
            end
         end
         ST_GROUP: begin
            if (pos_ff == 2'd0 && (symbol == CH_NUL || symbol == CH_CR)) begin
               direct_done = 1'b1;
            end else begin
               do_take = 1'b1;
            end
         end
         default: begin
            phase_sel = ST_START;
         end
      endcase
   end

   assign v         = sextet_of(symbol);
   assign pad       = (symbol == CH_PAD);
   assign bad       = v[6] && !(pad && t_pos[1]);
   assign held_base = (t_pos == 2'd0) ? 18'd0 : t_held;
   assign s1        = t_held[17:12];
   assign s2        = t_held[11:6];
   assign s3        = t_held[5:0];
   assign bytes[0]  = {s1, s2[5:4]};
   assign bytes[1]  = {s2[3:0], s3[5:2]};
   assign bytes[2]  = {s3[1:0], v[5:0]};
   assign nbytes    = t_tp ? 2'd1 : (pad ? 2'd2 : 2'd3);

   always_comb begin
      sum = {2'b00, count_ff} + (CNT_W+2)'(nbytes);
      if (sum > (CNT_W+2)'(COUNT_MAX)) begin
         count_sat = CNT_W'(COUNT_MAX);
      end else begin
         count_sat = sum[CNT_W-1:0];
      end
   end

   // Done results report the count after this group's bytes; a direct done (CR or NUL) reports the stored count.
   always_comb begin
      if (direct_done) begin
         count_ext = {16'd0, count_ff};
      end else begin
         count_ext = {16'd0, count_sat};
      end
   end
   assign done_count = count_ext[15:0];

   always_comb begin
      push_c     = '0;
      phase_in   = phase_sel;
      pos_in     = pos_ff;
      held_in    = held_ff;
      tp_in      = tp_ff;
      count_in   = count_ff;
      new_string = 1'b0;
      if (direct_done) begin
         push_c.num            = 2'd1;
         push_c.items[0].kind  = KIND_DONE;
         push_c.items[0].count = done_count;
         new_string            = 1'b1;
      end else if (do_take) begin
         if (bad) begin
            push_c.num           = 2'd1;
            push_c.items[0].kind = KIND_ERROR;
            new_string           = 1'b1;
         end else if (t_pos != 2'd3) begin
            phase_in = ST_GROUP;
            held_in  = {held_base[11:0], pad ? 6'd0 : v[5:0]};
            pos_in   = t_pos + 2'd1;
            tp_in    = (t_pos == 2'd2) ? pad : ((t_pos == 2'd0) ? 1'b0 : t_tp);
         end else begin
            phase_in = ST_GROUP;
            pos_in   = 2'd0;
            count_in = count_sat;
            for (int i = 0; i < MAX_RESULTS; i++) begin
               if (2'(i) < nbytes) begin
                  push_c.items[i].kind = KIND_DATA;
                  push_c.items[i].data = bytes[i];
               end else if (pad && 2'(i) == nbytes) begin
                  push_c.items[i].kind  = KIND_DONE;
                  push_c.items[i].count = done_count;
               end
            end
            push_c.num = pad ? nbytes + 2'd1 : nbytes;
            new_string = pad;
         end
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         push_c.items[i].last = (2'(i) + 2'd1 == push_c.num);
      end
      if (!accept) begin
         push_c.num = 2'd0;
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_START;
         pos_ff   <= 2'd0;
         held_ff  <= 18'd0;
         tp_ff    <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         if (new_string) begin
            phase_ff <= ST_START;
            pos_ff   <= 2'd0;
            held_ff  <= 18'd0;
            tp_ff    <= 1'b0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            held_ff  <= held_in;
            tp_ff    <= tp_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// File: sv/b64d_queue.sv
// Result queue: takes up to three results per cycle and hands out one per cycle while the consumer is ready.
module b64d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  b64d_pkg::push_type   push,
   input  logic                 pop_ready,
   output logic                 head_valid,
   output b64d_pkg::result_type head,
   output logic                 has_room
);
   import b64d_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       mem [QUEUE_DEPTH];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             pop;

   assign head_valid = (fill_ff != '0);
   assign head       = mem[head_ff];
   assign pop        = head_valid && pop_ready;
   assign has_room   = (fill_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

   assign head_in = pop ? head_ff + IDX_W'(1) : head_ff;
   assign tail_in = tail_ff + IDX_W'(push.num);
   assign fill_in = fill_ff + CNT_W'(push.num) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.num) begin
            mem[tail_ff + IDX_W'(i)] <= push.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule
